// ===== rtl/pade_cloud_optics_eval_assert.svh =====
// Assertion macros used by the checker file of the cloud optics evaluator.
`ifndef PADE_CLOUD_OPTICS_EVAL_ASSERT_SVH
`define PADE_CLOUD_OPTICS_EVAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCO_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pco check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCO_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pco check failed");

`endif

// ===== rtl/pco_pkg.sv =====
// Types, codes and arithmetic helpers of the cloud optics evaluator.
`default_nettype none
package pco_pkg;

	localparam int NUM_BANDS_DEF   = 16;
	localparam int NUM_REGIMES_DEF = 4;
	localparam int MAX_TERMS_DEF   = 8;

	// action codes
	localparam logic [1:0] ACT_COMPUTE     = 2'd0;
	localparam logic [1:0] ACT_LOAD_COEF   = 2'd1;
	localparam logic [1:0] ACT_LOAD_REGIME = 2'd2;

	// regime word selectors
	localparam logic [2:0] RSEL_LOWER = 3'd0;
	localparam logic [2:0] RSEL_UPPER = 3'd1;
	localparam logic [2:0] RSEL_REF   = 3'd2;

	localparam logic [2:0] NUM_TABLES = 3'd6;

	// configuration register indexes
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 4;
	localparam logic [CFG_IW-1:0] CFG_NUMER   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_DENOM   = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_REGIMES = 2'd2;

	localparam logic [3:0] NUMER_RST   = 4'd8;
	localparam logic [3:0] DENOM_RST   = 4'd8;
	localparam logic [2:0] REGIMES_RST = 3'd4;

	// divider: 48-bit dividend, one bit a cycle
	localparam int         DIV_CW    = 6;
	localparam logic [5:0] DIV_STEPS = 6'd48;

	typedef struct packed {
		logic [1:0]         action;
		logic [3:0]         band;
		logic [1:0]         regime;
		logic [2:0]         table_sel;
		logic [2:0]         term;
		logic signed [31:0] load_value;
		logic signed [31:0] water_content;
		logic signed [31:0] radius;
	} req_t;

	typedef struct packed {
		logic signed [31:0] extinction;
		logic signed [31:0] albedo;
		logic signed [31:0] asymmetry;
		logic               regime_found;
		logic               arith_error;
	} rsp_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_ACCEPT,
		DP_FOUND,
		DP_INIT,
		DP_MUL,
		DP_ADD,
		DP_NUM,
		DP_DIV_INIT,
		DP_DIV_STEP,
		DP_DIV_END,
		DP_EXT_MUL,
		DP_EXT_SAT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] tbl;
		logic [3:0] term;
		logic [3:0] ridx;
	} dp_cmd_t;

	typedef struct packed {
		logic gate_ok;
		logic hit;
	} dp_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_H_RD,
		ST_H_INIT,
		ST_H_MUL,
		ST_H_ADD,
		ST_H_END,
		ST_DIV_RUN,
		ST_DIV_END,
		ST_EXT_MUL,
		ST_EXT_SAT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} sat_t;

	// saturate a wide signed value to Q16.16
	function automatic sat_t sat32(input logic signed [63:0] x);
		sat_t r;
		if (x > 64'sh0000_0000_7FFF_FFFF) begin
			r.ovf = 1'b1;
			r.val = 32'sh7FFF_FFFF;
		end else if (x < -64'sh0000_0000_8000_0000) begin
			r.ovf = 1'b1;
			r.val = 32'sh8000_0000;
		end else begin
			r.ovf = 1'b0;
			r.val = x[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pco_dp.sv =====
// Datapath: coefficient and regime stores, shared multiplier, Horner accumulator, divider.
`default_nettype none
module pco_dp #(
	parameter int NUM_BANDS   = pco_pkg::NUM_BANDS_DEF,
	parameter int NUM_REGIMES = pco_pkg::NUM_REGIMES_DEF,
	parameter int MAX_TERMS   = pco_pkg::MAX_TERMS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pco_pkg::req_t    req,
	input  wire pco_pkg::dp_cmd_t cmd,
	output pco_pkg::dp_stat_t     stat,
	output pco_pkg::rsp_t         result
);
	import pco_pkg::*;

	localparam int CDEPTH = 6 * NUM_BANDS * NUM_REGIMES * MAX_TERMS;
	localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int RW     = (NUM_REGIMES > 1) ? $clog2(NUM_REGIMES) : 1;

	logic signed [31:0] coef_mem [CDEPTH];
	logic signed [31:0] lower_q [NUM_REGIMES];
	logic signed [31:0] upper_q [NUM_REGIMES];
	logic signed [31:0] ref_q [NUM_REGIMES];

	req_t               req_q;
	logic [RW-1:0]      reg_q;
	logic               found_q;
	logic               err_q;
	logic signed [31:0] d_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] num_q;
	logic signed [31:0] rdata_q;
	logic signed [63:0] prod_s1;
	logic signed [31:0] ext_q;
	logic signed [31:0] ssa_q;
	logic signed [31:0] asy_q;
	logic [47:0]        quo_q;
	logic [31:0]        rem_q;
	logic [31:0]        den_q;
	logic               neg_q;
	logic               dz_q;

	logic [31:0]        waddr_full;
	logic [31:0]        raddr_full;
	logic               coef_we;
	logic               reg_we;
	logic [RW-1:0]      ridx;
	logic [RW-1:0]      wreg;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	sat_t               qm;
	sat_t               sum;
	sat_t               dif;
	logic [32:0]        div_sh;
	logic signed [31:0] rat;
	logic               rat_err;

	// store addressing and write enables
	always_comb begin
		waddr_full = ((32'(req.table_sel) * NUM_BANDS + 32'(req.band)) * NUM_REGIMES
			+ 32'(req.regime)) * MAX_TERMS + 32'(req.term);
		raddr_full = ((32'(cmd.tbl) * NUM_BANDS + 32'(req_q.band)) * NUM_REGIMES
			+ 32'(reg_q)) * MAX_TERMS + 32'(cmd.term);
		coef_we = (cmd.op == DP_ACCEPT) && (req.action == ACT_LOAD_COEF)
			&& (32'(req.band) < NUM_BANDS) && (32'(req.regime) < NUM_REGIMES)
			&& (req.table_sel < NUM_TABLES) && (32'(req.term) < MAX_TERMS);
		reg_we = (cmd.op == DP_ACCEPT) && (req.action == ACT_LOAD_REGIME)
			&& (32'(req.regime) < NUM_REGIMES);
		wreg = RW'(req.regime);
		ridx = cmd.ridx[RW-1:0];
	end

	// coefficient memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[waddr_full[CAW-1:0]] <= req.load_value;
		end
		rdata_q <= coef_mem[raddr_full[CAW-1:0]];
	end

	// regime words
	always_ff @(posedge clk) begin
		if (reg_we) begin
			unique case (req.table_sel)
				RSEL_LOWER: lower_q[wreg] <= req.load_value;
				RSEL_UPPER: upper_q[wreg] <= req.load_value;
				RSEL_REF:   ref_q[wreg]   <= req.load_value;
				default: ;
			endcase
		end
	end

	// status back to the controller
	always_comb begin
		stat.gate_ok = (req_q.water_content > 32'sd0) && (32'(req_q.band) < NUM_BANDS);
		stat.hit     = (lower_q[ridx] <= req_q.radius) && (upper_q[ridx] >= req_q.radius);
	end

	// arithmetic around the shared multiplier and the divider
	always_comb begin
		mul_a  = (cmd.op == DP_EXT_MUL) ? req_q.water_content : d_q;
		mul_b  = (cmd.op == DP_EXT_MUL) ? ext_q : acc_q;
		qm     = sat32(prod_s1 >>> 16);
		sum    = sat32(64'(rdata_q) + 64'(qm.val));
		dif    = sat32(64'(req_q.radius) - 64'(ref_q[ridx]));
		div_sh = {rem_q, quo_q[47]};
		if (dz_q) begin
			rat_err = 1'b1;
			if (num_q > 32'sd0) begin
				rat = 32'sh7FFF_FFFF;
			end else if (num_q < 32'sd0) begin
				rat = 32'sh8000_0000;
			end else begin
				rat = 32'sd0;
			end
		end else if (neg_q) begin
			rat_err = quo_q > 48'h0000_8000_0000;
			rat     = rat_err ? 32'sh8000_0000 : 32'(~quo_q[31:0] + 32'd1);
		end else begin
			rat_err = quo_q > 48'h0000_7FFF_FFFF;
			rat     = rat_err ? 32'sh7FFF_FFFF : quo_q[31:0];
		end
	end

	// multiplier output register
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			unique case (cmd.op)
				DP_ACCEPT: begin
					found_q <= 1'b0;
					err_q   <= 1'b0;
				end
				DP_FOUND: begin
					found_q <= 1'b1;
					err_q   <= err_q | dif.ovf;
				end
				DP_ADD:     err_q <= err_q | qm.ovf | sum.ovf;
				DP_DIV_END: err_q <= err_q | rat_err;
				DP_EXT_SAT: err_q <= err_q | qm.ovf;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_ACCEPT: begin
				req_q <= req;
				ext_q <= 32'sd0;
				ssa_q <= 32'sd0;
				asy_q <= 32'sd0;
			end
			DP_FOUND: begin
				reg_q <= ridx;
				d_q   <= dif.val;
			end
			DP_INIT: acc_q <= rdata_q;
			DP_ADD:  acc_q <= sum.val;
			DP_NUM:  num_q <= acc_q;
			DP_DIV_INIT: begin
				quo_q <= {(num_q[31] ? 32'(-num_q) : num_q), 16'd0};
				rem_q <= 32'd0;
				den_q <= acc_q[31] ? 32'(-acc_q) : acc_q;
				neg_q <= num_q[31] ^ acc_q[31];
				dz_q  <= acc_q == 32'sd0;
			end
			// restoring step: one quotient bit
			DP_DIV_STEP: begin
				if (div_sh >= {1'b0, den_q}) begin
					rem_q <= 32'(div_sh - {1'b0, den_q});
					quo_q <= {quo_q[46:0], 1'b1};
				end else begin
					rem_q <= div_sh[31:0];
					quo_q <= {quo_q[46:0], 1'b0};
				end
			end
			DP_DIV_END: begin
				unique case (cmd.tbl[2:1])
					2'd0: ext_q <= rat;
					2'd1: ssa_q <= rat;
					2'd2: asy_q <= rat;
					default: ;
				endcase
			end
			DP_EXT_SAT: ext_q <= qm.val;
			default: ;
		endcase
	end

	always_comb begin
		result.extinction   = ext_q;
		result.albedo       = ssa_q;
		result.asymmetry    = asy_q;
		result.regime_found = found_q;
		result.arith_error  = err_q;
	end

endmodule
`default_nettype wire

// ===== rtl/pco_ctrl.sv =====
// Controller: configuration registers, sequencing state machine and loop counters.
`default_nettype none
module pco_ctrl #(
	parameter int NUM_REGIMES = pco_pkg::NUM_REGIMES_DEF,
	parameter int MAX_TERMS   = pco_pkg::MAX_TERMS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [1:0]                 action,
	input  wire logic                       cfg_we,
	input  wire logic [pco_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [pco_pkg::CFG_DW-1:0] cfg_data,
	input  wire pco_pkg::dp_stat_t          stat,
	output pco_pkg::dp_cmd_t                cmd,
	output logic                            busy,
	output logic                            done
);
	import pco_pkg::*;

	localparam int TCW = $clog2(MAX_TERMS + 1);
	localparam int RCW = $clog2(NUM_REGIMES + 1);

	state_t           state_q;
	state_t           state_nxt;
	logic [3:0]       numer_q;
	logic [3:0]       denom_q;
	logic [2:0]       regimes_q;
	logic [2:0]       tbl_q;
	logic [TCW-1:0]   term_q;
	logic [RCW-1:0]   ridx_q;
	logic [DIV_CW-1:0] cnt_q;

	logic [TCW-1:0]   nt;
	logic [TCW-1:0]   dt;
	logic [TCW-1:0]   tcount;
	logic [RCW-1:0]   rcount;
	logic             tbl_inc;
	logic             tbl_clr;
	logic             term_one;
	logic             term_inc;
	logic             ridx_inc;
	logic             ridx_clr;
	logic             cnt_clr;
	logic             cnt_inc;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numer_q   <= NUMER_RST;
			denom_q   <= DENOM_RST;
			regimes_q <= REGIMES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUMER:   numer_q   <= cfg_data;
				CFG_DENOM:   denom_q   <= cfg_data;
				CFG_REGIMES: regimes_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// clamped counts
	always_comb begin
		if (numer_q == 4'd0) begin
			nt = TCW'(1);
		end else if (32'(numer_q) > MAX_TERMS) begin
			nt = TCW'(MAX_TERMS);
		end else begin
			nt = TCW'(numer_q);
		end
		if (denom_q == 4'd0) begin
			dt = TCW'(1);
		end else if (32'(denom_q) > MAX_TERMS) begin
			dt = TCW'(MAX_TERMS);
		end else begin
			dt = TCW'(denom_q);
		end
		rcount = (32'(regimes_q) > NUM_REGIMES) ? RCW'(NUM_REGIMES) : RCW'(regimes_q);
		tcount = tbl_q[0] ? dt : nt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd.op    = DP_NOP;
		cmd.tbl   = tbl_q;
		cmd.term  = 4'(term_q);
		cmd.ridx  = 4'(ridx_q);
		busy      = 1'b1;
		done      = 1'b0;
		tbl_inc   = 1'b0;
		tbl_clr   = 1'b0;
		term_one  = 1'b0;
		term_inc  = 1'b0;
		ridx_inc  = 1'b0;
		ridx_clr  = 1'b0;
		cnt_clr   = 1'b0;
		cnt_inc   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				ridx_clr = 1'b1;
				if (start) begin
					cmd.op = DP_ACCEPT;
					if (action == ACT_COMPUTE) begin
						state_nxt = ST_SEARCH;
					end
				end
			end
			// one regime compared per cycle, first hit wins
			ST_SEARCH: begin
				if (!stat.gate_ok || rcount == '0) begin
					state_nxt = ST_DONE;
				end else if (stat.hit) begin
					cmd.op    = DP_FOUND;
					tbl_clr   = 1'b1;
					state_nxt = ST_H_RD;
				end else if (32'(ridx_q) + 32'd1 >= 32'(rcount)) begin
					state_nxt = ST_DONE;
				end else begin
					ridx_inc = 1'b1;
				end
			end
			ST_H_RD: begin
				cmd.term  = 4'd0;
				state_nxt = ST_H_INIT;
			end
			ST_H_INIT: begin
				cmd.op    = DP_INIT;
				term_one  = 1'b1;
				state_nxt = (tcount == TCW'(1)) ? ST_H_END : ST_H_MUL;
			end
			ST_H_MUL: begin
				cmd.op    = DP_MUL;
				state_nxt = ST_H_ADD;
			end
			ST_H_ADD: begin
				cmd.op   = DP_ADD;
				term_inc = 1'b1;
				if (32'(term_q) + 32'd1 >= 32'(tcount)) begin
					state_nxt = ST_H_END;
				end else begin
					state_nxt = ST_H_MUL;
				end
			end
			ST_H_END: begin
				if (tbl_q[0]) begin
					cmd.op    = DP_DIV_INIT;
					cnt_clr   = 1'b1;
					state_nxt = ST_DIV_RUN;
				end else begin
					cmd.op    = DP_NUM;
					tbl_inc   = 1'b1;
					state_nxt = ST_H_RD;
				end
			end
			ST_DIV_RUN: begin
				cmd.op  = DP_DIV_STEP;
				cnt_inc = 1'b1;
				if (cnt_q == DIV_STEPS - 6'd1) begin
					state_nxt = ST_DIV_END;
				end
			end
			ST_DIV_END: begin
				cmd.op = DP_DIV_END;
				if (tbl_q == 3'd1) begin
					state_nxt = ST_EXT_MUL;
				end else if (tbl_q == NUM_TABLES - 3'd1) begin
					state_nxt = ST_DONE;
				end else begin
					tbl_inc   = 1'b1;
					state_nxt = ST_H_RD;
				end
			end
			ST_EXT_MUL: begin
				cmd.op    = DP_EXT_MUL;
				state_nxt = ST_EXT_SAT;
			end
			ST_EXT_SAT: begin
				cmd.op    = DP_EXT_SAT;
				tbl_inc   = 1'b1;
				state_nxt = ST_H_RD;
			end
			ST_DONE: begin
				done      = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_q  <= '0;
			term_q <= '0;
			ridx_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (tbl_clr) begin
				tbl_q <= '0;
			end else if (tbl_inc) begin
				tbl_q <= tbl_q + 3'd1;
			end
			if (term_one) begin
				term_q <= TCW'(1);
			end else if (term_inc) begin
				term_q <= term_q + TCW'(1);
			end
			if (ridx_clr) begin
				ridx_q <= '0;
			end else if (ridx_inc) begin
				ridx_q <= ridx_q + RCW'(1);
			end
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pade_cloud_optics_eval.sv =====
// Top level of the Pade rational cloud optics evaluator.
//
// Usage:
//  - An input word is taken at a rising edge with start high and busy low.
//    action selects compute, coefficient load or regime load.
//  - Loads write the store in the accepting cycle and give no result; busy
//    stays low, so loads may follow each other every cycle.
//  - A compute raises busy and, when finished, shows the result word on
//    result for one cycle with done high. The receiver cannot hold it off.
//  - A compute searches the regimes, evaluates six polynomials by Horner's
//    rule and performs three divisions and the water content multiply. The
//    bit-serial divider and the one shared multiplier set its length. No
//    match or dry air finishes without any polynomial evaluation.
//  - Configuration is written through cfg_we/cfg_index/cfg_data while idle.
//  - Reset returns the controller to idle and the term and regime counts to
//    their defaults; store contents are undefined until loaded.
`default_nettype none
module pade_cloud_optics_eval #(
	parameter int NUM_BANDS   = pco_pkg::NUM_BANDS_DEF,
	parameter int NUM_REGIMES = pco_pkg::NUM_REGIMES_DEF,
	parameter int MAX_TERMS   = pco_pkg::MAX_TERMS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire pco_pkg::req_t              req,
	input  wire logic                       cfg_we,
	input  wire logic [pco_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [pco_pkg::CFG_DW-1:0] cfg_data,
	output logic                            done,
	output pco_pkg::rsp_t                   result
);
	import pco_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pco_ctrl #(
		.NUM_REGIMES(NUM_REGIMES),
		.MAX_TERMS  (MAX_TERMS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.action   (req.action),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	pco_dp #(
		.NUM_BANDS  (NUM_BANDS),
		.NUM_REGIMES(NUM_REGIMES),
		.MAX_TERMS  (MAX_TERMS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.stat  (stat),
		.result(result)
	);

endmodule
`default_nettype wire

// ===== rtl/pco_checker.sv =====
// Port-level checker of the cloud optics evaluator, bound to the top level.
`default_nettype none
`include "pade_cloud_optics_eval_assert.svh"
module pco_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire pco_pkg::req_t req,
	input wire logic          done,
	input wire pco_pkg::rsp_t result
);
	import pco_pkg::*;

	logic optics_zero;

	// all three optics values at zero
	assign optics_zero = (result.extinction == 32'sd0) && (result.albedo == 32'sd0)
		&& (result.asymmetry == 32'sd0);

	// a result word only comes out of a running compute
	`PCO_ASSERT_NOW(a_done_busy, clk, arst_n, done, busy)
	// the block returns to idle straight after the result word
	`PCO_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy)
	// a compute word starts work, a load word does not
	`PCO_ASSERT_NEXT(a_comp_busy, clk, arst_n, start && !busy && req.action == ACT_COMPUTE, busy)
	`PCO_ASSERT_NEXT(a_load_idle, clk, arst_n, start && !busy && req.action != ACT_COMPUTE, !busy)
	// no regime found means zero optics
	`PCO_ASSERT_NOW(a_miss_zero, clk, arst_n, done && !result.regime_found, optics_zero)

endmodule

bind pade_cloud_optics_eval pco_checker u_chk (.*);
`default_nettype wire
